// File: design/atsc_pkg.sv
// shared types and constants for the adaptive time sync client
// no dependencies
package atsc_pkg;

    localparam logic [2:0]  ST_IDLE     = 3'd0;
    localparam logic [2:0]  ST_REQUEST  = 3'd1;
    localparam logic [2:0]  ST_BAD      = 3'd2;
    localparam logic [2:0]  ST_STALE    = 3'd3;
    localparam logic [2:0]  ST_RTT_LONG = 3'd4;
    localparam logic [2:0]  ST_UPDATED  = 3'd5;

    localparam logic        CMD_TICK     = 1'b0;
    localparam logic        CMD_RESPONSE = 1'b1;

    localparam logic [1:0]  REG_MAX_RT   = 2'd0;
    localparam logic [1:0]  REG_DESIRED  = 2'd1;
    localparam logic [1:0]  REG_MIN_SEND = 2'd2;
    localparam logic [1:0]  REG_MAX_SEND = 2'd3;

    localparam logic [23:0] RST_MAX_RT   = 24'd1000;
    localparam logic [23:0] RST_DESIRED  = 24'd60000;
    localparam logic [23:0] RST_MIN_SEND = 24'd1000;
    localparam logic [23:0] RST_MAX_SEND = 24'd10000;

    localparam logic [23:0] HDR_TSP = 24'h545350;
    localparam logic [15:0] MIN_LEN = 16'd24;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_PREP_T = 9'b000000010,
        S_DIV_T  = 9'b000000100,
        S_PREP_R = 9'b000001000,
        S_DIV_R  = 9'b000010000,
        S_MUL_C  = 9'b000100000,
        S_MUL_I  = 9'b001000000,
        S_MUL_L  = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

endpackage

// File: design/adaptive_time_sync_client_unit.sv
// adaptive time sync client: request timing, response checks, offset update
// depends on atsc_pkg
//
// One request at a time: ready drops after acceptance and the result appears
// on the output register. An item that needs no limit update (no request,
// bad or stale or too-long response, or no accepted response yet) goes
// straight from idle to the done state. A limit update runs the bit-serial
// divider, which computes the two quality factors one quotient bit a cycle,
// followed by three passes through one shared multiplier. Config writes are
// taken every cycle.
module adaptive_time_sync_client_unit
    import atsc_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_packet_length,
    input  logic [23:0] i_header_bytes,
    input  logic [63:0] i_response_cookie,
    input  logic [63:0] i_server_epoch_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_request_cookie,
    output logic        o_time_valid,
    output logic [63:0] o_clock_offset_ms,
    output logic [23:0] o_send_interval_ms,
    output logic [23:0] o_rtt_limit_ms,
    output logic [31:0] o_round_trip_ms
);

    localparam int FB = FRACTION_BITS;
    localparam int MW = (FB + 1 > 24) ? FB + 1 : 24;
    localparam int CW = $clog2(FB);
    localparam logic [FB:0]   ONE = {1'b1, {FB{1'b0}}};
    localparam logic [CW-1:0] LAST_STEP = CW'(FB - 1);

    t_state r_state;

    logic [23:0] r_max_rt, r_desired, r_min_send, r_max_send;
    logic [31:0] r_last_send, r_pending_cookie, r_last_update, r_now;
    logic        r_pending_valid, r_valid_flag;
    logic [23:0] r_last_rt;
    logic [63:0] r_offset;
    logic [23:0] r_interval, r_rtt_limit;

    // divider and multiplier datapath
    logic [23:0]   r_rem, r_den;
    logic [FB-1:0] r_quo;
    logic          r_ovf;
    logic [CW-1:0] r_cnt;
    logic [FB:0]   r_fac_t, r_c;
    logic [MW-1:0] r_ma, r_mb;

    logic [2:0]  r_status;
    logic [31:0] r_req, r_rtt_out;

    logic          accept;
    logic [31:0]   since_send, num_t, rt_meas;
    logic          hdr_ok, cookie_ok, rtt_long;
    logic [24:0]   rem2;
    logic          step_bit;
    logic [FB-1:0] quo_fin;
    logic [FB:0]   fac;
    logic [2*MW-1:0] prod;
    logic [2*MW-1:0] prod_sh;
    logic [FB:0]   c_next;
    logic [23:0]   diff;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = (r_state == S_DONE);

    assign since_send = i_now_ms - r_last_send;
    assign rt_meas    = i_now_ms - r_last_send;
    assign num_t      = r_now - r_last_update;
    assign hdr_ok     = (i_packet_length >= MIN_LEN) && (i_header_bytes == HDR_TSP);
    assign cookie_ok  = r_pending_valid && (i_response_cookie == {32'd0, r_pending_cookie});
    assign rtt_long   = rt_meas >= {8'd0, r_rtt_limit};

    // one restoring divide step
    assign rem2     = {r_rem, 1'b0};
    assign step_bit = rem2 >= {1'b0, r_den};
    assign quo_fin  = {r_quo[FB-2:0], step_bit};
    assign fac      = r_ovf ? '0 : (ONE - {1'b0, quo_fin});

    assign prod    = r_ma * r_mb;
    assign prod_sh = prod >> FB;
    assign c_next  = (prod_sh > {{(2*MW-FB-1){1'b0}}, ONE}) ? ONE : prod_sh[FB:0];
    assign diff    = (r_max_send > r_min_send) ? (r_max_send - r_min_send) : 24'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_max_rt         <= RST_MAX_RT;
            r_desired        <= RST_DESIRED;
            r_min_send       <= RST_MIN_SEND;
            r_max_send       <= RST_MAX_SEND;
            r_last_send      <= '0;
            r_pending_cookie <= '0;
            r_pending_valid  <= 1'b0;
            r_last_update    <= '0;
            r_last_rt        <= '0;
            r_valid_flag     <= 1'b0;
            r_offset         <= '0;
            r_interval       <= RST_MIN_SEND;
            r_rtt_limit      <= RST_MAX_RT;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MAX_RT:   r_max_rt   <= (i_cfg_data != 0) ? i_cfg_data : RST_MAX_RT;
                    REG_DESIRED:  r_desired  <= (i_cfg_data != 0) ? i_cfg_data : RST_DESIRED;
                    REG_MIN_SEND: r_min_send <= (i_cfg_data != 0) ? i_cfg_data : RST_MIN_SEND;
                    REG_MAX_SEND: r_max_send <= (i_cfg_data != 0) ? i_cfg_data : RST_MAX_SEND;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now     <= i_now_ms;
                        r_req     <= '0;
                        r_rtt_out <= '0;
                        r_status  <= ST_IDLE;
                        r_state   <= S_DONE;
                        if (i_command == CMD_TICK) begin
                            if (since_send > {8'd0, r_interval}) begin
                                r_last_send      <= i_now_ms;
                                r_pending_cookie <= i_now_ms;
                                r_pending_valid  <= 1'b1;
                                r_req            <= i_now_ms;
                                r_status         <= ST_REQUEST;
                                if (r_valid_flag) begin
                                    r_state <= S_PREP_T;
                                end else begin
                                    r_interval  <= r_min_send;
                                    r_rtt_limit <= r_max_rt;
                                end
                            end
                        end else if (!hdr_ok) begin
                            r_status <= ST_BAD;
                        end else if (!cookie_ok) begin
                            r_status <= ST_STALE;
                        end else begin
                            r_pending_valid  <= 1'b0;
                            r_pending_cookie <= '0;
                            r_rtt_out        <= rt_meas;
                            if (rtt_long) begin
                                r_status <= ST_RTT_LONG;
                            end else begin
                                r_last_update <= i_now_ms;
                                r_last_rt     <= rt_meas[23:0];
                                r_valid_flag  <= 1'b1;
                                r_offset      <= i_server_epoch_ms
                                                 - {32'd0, i_now_ms - (rt_meas >> 1)};
                                r_status      <= ST_UPDATED;
                                r_state       <= S_PREP_T;
                            end
                        end
                    end
                end
                S_PREP_T: begin
                    r_ovf   <= num_t >= {8'd0, r_desired};
                    r_rem   <= num_t[23:0];
                    r_den   <= r_desired;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV_T;
                end
                S_DIV_T, S_DIV_R: begin
                    r_rem <= step_bit ? 24'(rem2 - {1'b0, r_den}) : rem2[23:0];
                    r_quo <= quo_fin;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        if (r_state == S_DIV_T) begin
                            r_fac_t <= fac;
                            r_state <= S_PREP_R;
                        end else begin
                            r_ma    <= MW'(r_fac_t);
                            r_mb    <= MW'(fac);
                            r_state <= S_MUL_C;
                        end
                    end
                end
                S_PREP_R: begin
                    r_ovf   <= r_last_rt >= r_max_rt;
                    r_rem   <= r_last_rt;
                    r_den   <= r_max_rt;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV_R;
                end
                S_MUL_C: begin
                    r_c     <= c_next;
                    r_ma    <= MW'(diff);
                    r_mb    <= MW'(c_next);
                    r_state <= S_MUL_I;
                end
                S_MUL_I: begin
                    r_interval <= r_min_send + prod_sh[23:0];
                    r_ma       <= MW'(r_max_rt);
                    r_mb       <= MW'(r_c);
                    r_state    <= S_MUL_L;
                end
                S_MUL_L: begin
                    r_rtt_limit <= r_max_rt - prod_sh[23:0];
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_status           = r_status;
    assign o_request_cookie   = r_req;
    assign o_time_valid       = r_valid_flag;
    assign o_clock_offset_ms  = r_offset;
    assign o_send_interval_ms = r_interval;
    assign o_rtt_limit_ms     = r_rtt_limit;
    assign o_round_trip_ms    = r_rtt_out;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready) else $error("ready while busy");
    a_updated_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_UPDATED) |-> o_time_valid)
        else $error("update without time valid");
    a_cookie_only_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_REQUEST) |-> (o_request_cookie == 32'd0))
        else $error("cookie on non-request");
    a_rtt_only_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_RTT_LONG && o_status != ST_UPDATED)
        |-> (o_round_trip_ms == 32'd0)) else $error("round trip on wrong status");
`endif

endmodule
